// ----- hw/rtl/qtbe_pkg.sv -----
// ---------------------------------------------------------------------------
// qtbe_pkg
// shared constants and codes for the quadtree bitmap encoder
// ---------------------------------------------------------------------------
`default_nettype none

package qtbe_pkg;

  // default geometry limits
  localparam int MAX_DIM_DEFAULT     = 64;
  localparam int STACK_DEPTH_DEFAULT = 32;

  // fixed field widths
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int SYMBOL_W    = 2;
  localparam int LOAD_W      = 13;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT = 1'b1;

  // command opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // output symbol codes
  localparam logic [SYMBOL_W-1:0] SYM_ZERO   = 2'd0;
  localparam logic [SYMBOL_W-1:0] SYM_ONE    = 2'd1;
  localparam logic [SYMBOL_W-1:0] SYM_DIVIDE = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/qtbe_ram.sv -----
// ---------------------------------------------------------------------------
// qtbe_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module qtbe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/quadtree_bitmap_encoder_top.sv -----
// Loads leave busy low.
// A pull holds busy high while the top region is popped and its pixels are read
// until the region is decided; the result strobe marks that decision.
// A divide adds stack pushes of two or four child regions.
// The pixel store gives one pixel per cycle through its single read port.
// Synchronous reset: phase loading, dims 1, stack empty; rams are not cleared.
// ---------------------------------------------------------------------------
// quadtree_bitmap_encoder_top
// two-level bitmap loader and depth-first quadtree symbol generator
// ---------------------------------------------------------------------------
`default_nettype none

module quadtree_bitmap_encoder_top #(
  parameter int MAX_DIM     = qtbe_pkg::MAX_DIM_DEFAULT,
  parameter int STACK_DEPTH = qtbe_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode,
  input  wire logic                             pixel,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qtbe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [qtbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  result_valid,
  output logic [qtbe_pkg::SYMBOL_W-1:0]         symbol,
  output logic                                  last
);

  import qtbe_pkg::*;

  localparam int COORD_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int STORE_SIZE = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int CMP_W      = (LOAD_W > AREA_W) ? LOAD_W : AREA_W;
  localparam int MUL_W      = COORD_W + DIM_W + 1;
  localparam int SP_W       = $clog2(STACK_DEPTH);
  localparam int LVL_W      = $clog2(STACK_DEPTH + 1);
  localparam int REG_W      = 2 * COORD_W + 2 * DIM_W;

  typedef enum logic [2:0] {
    PH_LOADING  = 3'b001,
    PH_EMITTING = 3'b010,
    PH_DONE     = 3'b100
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_POPW = 5'b00010,
    ST_BASE = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  state_t                state;
  phase_t                phase;
  logic [LOAD_W-1:0]     load_count;
  logic [ADDR_W-1:0]     wr_addr;
  logic [LVL_W-1:0]      level;
  logic [DIM_W-1:0]      rows_c;
  logic [DIM_W-1:0]      cols_c;
  logic [AREA_W-1:0]     area;

  // current region
  logic [COORD_W-1:0]    r0;
  logic [COORD_W-1:0]    c0;
  logic [DIM_W-1:0]      nr;
  logic [DIM_W-1:0]      nc;

  // scan walker
  logic [ADDR_W-1:0]     row_base;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DIM_W-1:0]      i_cnt;
  logic [DIM_W-1:0]      j_cnt;
  logic                  issuing;
  logic                  pend;
  logic                  pend_first;
  logic                  pend_last;
  logic                  first_px;
  logic [1:0]            push_k;

  // ram ports
  logic                  pix_we;
  logic [ADDR_W-1:0]     pix_waddr;
  logic                  pix_re;
  logic                  pix_rdata;
  logic                  stk_we;
  logic [SP_W-1:0]       stk_waddr;
  logic [REG_W-1:0]      stk_wdata;
  logic                  stk_re;
  logic [SP_W-1:0]       stk_raddr;
  logic [REG_W-1:0]      stk_rdata;

  // decode helpers
  logic                  load_fire;
  logic                  pull_fire;
  logic                  restart;
  logic [LOAD_W-1:0]     cnt_cur;
  logic [ADDR_W-1:0]     addr_cur;
  logic [LOAD_W-1:0]     load_count_next;
  logic [ADDR_W-1:0]     wr_addr_next;
  logic                  image_full;
  logic                  last_issue;
  logic                  stack_room;
  logic [MUL_W-1:0]      base_w;
  logic [ADDR_W:0]       next_row_w;

  // split geometry
  logic [DIM_W:0]        nr_p1;
  logic [DIM_W:0]        nc_p1;
  logic [DIM_W-1:0]      hr;
  logic [DIM_W-1:0]      lr;
  logic [DIM_W-1:0]      hc;
  logic [DIM_W-1:0]      lc;
  logic [DIM_W:0]        r_mid_w;
  logic [DIM_W:0]        c_mid_w;
  logic [COORD_W-1:0]    r_mid;
  logic [COORD_W-1:0]    c_mid;
  logic                  col_split;
  logic                  row_split;
  logic [1:0]            push_k_last;
  logic [REG_W-1:0]      push_region;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // command decode
  assign load_fire = (state == ST_IDLE) && start && (opcode == OP_LOAD) &&
                     (phase != PH_EMITTING);
  assign pull_fire = (state == ST_IDLE) && start && (opcode == OP_PULL) &&
                     (phase == PH_EMITTING) && (level != '0);
  assign restart   = (phase == PH_DONE);
  assign cnt_cur   = restart ? '0 : load_count;
  assign addr_cur  = restart ? '0 : wr_addr;
  assign load_count_next = cnt_cur + LOAD_W'(1);
  assign wr_addr_next    = ((cnt_cur == '1) || (addr_cur == ADDR_W'(STORE_SIZE - 1))) ?
                           '0 : addr_cur + ADDR_W'(1);
  assign image_full      = CMP_W'(load_count_next) >= CMP_W'(area);

  // scan address arithmetic
  assign last_issue = (i_cnt == nr - DIM_W'(1)) && (j_cnt == nc - DIM_W'(1));
  assign base_w     = MUL_W'(r0) * MUL_W'(cols_c) + MUL_W'(c0);
  assign next_row_w = (ADDR_W + 1)'(row_base) + (ADDR_W + 1)'(cols_c);
  assign stack_room = (level < LVL_W'(STACK_DEPTH));

  // child region geometry, upper and left parts take the ceiling half
  assign nr_p1     = (DIM_W + 1)'(nr) + (DIM_W + 1)'(1);
  assign nc_p1     = (DIM_W + 1)'(nc) + (DIM_W + 1)'(1);
  assign hr        = nr_p1[DIM_W:1];
  assign hc        = nc_p1[DIM_W:1];
  assign lr        = nr >> 1;
  assign lc        = nc >> 1;
  assign r_mid_w   = (DIM_W + 1)'(r0) + (DIM_W + 1)'(hr);
  assign c_mid_w   = (DIM_W + 1)'(c0) + (DIM_W + 1)'(hc);
  assign r_mid     = r_mid_w[COORD_W-1:0];
  assign c_mid     = c_mid_w[COORD_W-1:0];
  assign col_split = (nc == DIM_W'(1));
  assign row_split = (nr == DIM_W'(1));
  assign push_k_last = (col_split || row_split) ? 2'd1 : 2'd3;

  // pushes go in reverse so the first part pops first
  always_comb begin
    push_region = {r0, c0, hr, hc};
    if (col_split) begin
      if (push_k == 2'd0) begin
        push_region = {r_mid, c0, lr, DIM_W'(1)};
      end else begin
        push_region = {r0, c0, hr, DIM_W'(1)};
      end
    end else if (row_split) begin
      if (push_k == 2'd0) begin
        push_region = {r0, c_mid, DIM_W'(1), lc};
      end else begin
        push_region = {r0, c0, DIM_W'(1), hc};
      end
    end else begin
      case (push_k)
        2'd0:    push_region = {r_mid, c_mid, lr, lc};
        2'd1:    push_region = {r_mid, c0, lr, hc};
        2'd2:    push_region = {r0, c_mid, hr, lc};
        default: push_region = {r0, c0, hr, hc};
      endcase
    end
  end

  // ram control
  always_comb begin
    pix_we    = load_fire;
    pix_waddr = addr_cur;
    pix_re    = (state == ST_SCAN) && issuing;
    stk_re    = pull_fire;
    stk_raddr = SP_W'(level - LVL_W'(1));
    stk_we    = 1'b0;
    stk_waddr = level[SP_W-1:0];
    stk_wdata = push_region;
    if (load_fire && image_full) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {COORD_W'(0), COORD_W'(0), rows_c, cols_c};
    end else if ((state == ST_PUSH) && stack_room) begin
      stk_we = 1'b1;
    end
  end

  qtbe_ram #(
    .WIDTH (1),
    .DEPTH (STORE_SIZE),
    .AW    (ADDR_W)
  ) u_pixel_store (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pixel),
    .re    (pix_re),
    .raddr (rd_addr),
    .rdata (pix_rdata)
  );

  qtbe_ram #(
    .WIDTH (REG_W),
    .DEPTH (STACK_DEPTH),
    .AW    (SP_W)
  ) u_region_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // configuration registers, area product kept alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_c <= DIM_W'(1);
      cols_c <= DIM_W'(1);
      area   <= AREA_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_COUNT: begin
          rows_c <= clamp_dim(cfg_data);
          area   <= AREA_W'(clamp_dim(cfg_data)) * AREA_W'(cols_c);
        end
        CFG_COL_COUNT: begin
          cols_c <= clamp_dim(cfg_data);
          area   <= AREA_W'(rows_c) * AREA_W'(clamp_dim(cfg_data));
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_LOADING;
      load_count   <= '0;
      wr_addr      <= '0;
      level        <= '0;
      issuing      <= 1'b0;
      pend         <= 1'b0;
      push_k       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          // pixel load, possibly finishing the image
          if (load_fire) begin
            load_count <= load_count_next;
            wr_addr    <= wr_addr_next;
            if (image_full) begin
              phase <= PH_EMITTING;
              level <= LVL_W'(1);
            end else begin
              phase <= PH_LOADING;
            end
          end
          // pull pops the top region
          if (pull_fire) begin
            level <= level - LVL_W'(1);
            state <= ST_POPW;
          end
        end
        ST_POPW: begin
          {r0, c0, nr, nc} <= stk_rdata;
          state            <= ST_BASE;
        end
        ST_BASE: begin
          rd_addr  <= base_w[ADDR_W-1:0];
          row_base <= base_w[ADDR_W-1:0];
          i_cnt    <= '0;
          j_cnt    <= '0;
          issuing  <= 1'b1;
          pend     <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // issue side: walk the region row by row
          pend       <= issuing;
          pend_first <= issuing && (i_cnt == '0) && (j_cnt == '0);
          pend_last  <= issuing && last_issue;
          if (issuing) begin
            if (last_issue) begin
              issuing <= 1'b0;
            end else if (j_cnt == nc - DIM_W'(1)) begin
              j_cnt    <= '0;
              i_cnt    <= i_cnt + DIM_W'(1);
              row_base <= next_row_w[ADDR_W-1:0];
              rd_addr  <= next_row_w[ADDR_W-1:0];
            end else begin
              j_cnt   <= j_cnt + DIM_W'(1);
              rd_addr <= rd_addr + ADDR_W'(1);
            end
          end
          // compare side: decide uniform or divide
          if (pend) begin
            if (pend_first) begin
              first_px <= pix_rdata;
              if (pend_last) begin
                result_valid <= 1'b1;
                symbol       <= pix_rdata ? SYM_ONE : SYM_ZERO;
                last         <= (level == '0);
                if (level == '0) begin
                  phase <= PH_DONE;
                end
                issuing <= 1'b0;
                state   <= ST_IDLE;
              end
            end else if (pix_rdata != first_px) begin
              result_valid <= 1'b1;
              symbol       <= SYM_DIVIDE;
              last         <= 1'b0;
              issuing      <= 1'b0;
              push_k       <= '0;
              state        <= ST_PUSH;
            end else if (pend_last) begin
              result_valid <= 1'b1;
              symbol       <= first_px ? SYM_ONE : SYM_ZERO;
              last         <= (level == '0);
              if (level == '0) begin
                phase <= PH_DONE;
              end
              issuing <= 1'b0;
              state   <= ST_IDLE;
            end
          end
        end
        ST_PUSH: begin
          // one child per cycle, dropped when the stack is full
          if (stack_room) begin
            level <= level + LVL_W'(1);
          end
          if (push_k == push_k_last) begin
            state <= ST_IDLE;
          end else begin
            push_k <= push_k + 2'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/qtbe_checker.sv -----
// ---------------------------------------------------------------------------
// qtbe_checker
// port-level checks on the quadtree encoder, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module qtbe_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             opcode,
  input wire logic                             pixel,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [qtbe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [qtbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input wire logic                             result_valid,
  input wire logic [qtbe_pkg::SYMBOL_W-1:0]    symbol,
  input wire logic                             last
);

  import qtbe_pkg::*;

  // symbol code is always one of the three defined codes
  a_symbol_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (symbol == SYM_ZERO || symbol == SYM_ONE || symbol == SYM_DIVIDE))
    else $error("undefined symbol code");

  // a load transfer never starts work or produces a symbol
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_LOAD) |=> (!busy && !result_valid))
    else $error("load transfer caused activity");

  // the final symbol leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("busy after final symbol");

  // a divide is never final and is followed by child pushes
  a_divide_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && symbol == SYM_DIVIDE) |-> (busy && !last))
    else $error("divide symbol without pending children");

  // busy only rises after a pull transfer
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && opcode == OP_PULL))
    else $error("busy rose without a pull");

endmodule

bind quadtree_bitmap_encoder_top qtbe_checker u_qtbe_checker (.*);

`default_nettype wire
